[rtl/tbo_pkg.sv]
// Shared constants for the triangle / box overlap pipeline.
`timescale 1ns / 1ps

package tbo_pkg;

    localparam int FIELD_BITS    = 63;   // one packed x,y,z field
    localparam int NUM_IN_FIELDS = 5;
    localparam int S_TDATA_BITS  = 320;  // five fields padded to whole bytes
    localparam int M_TDATA_BITS  = 8;
    localparam int NUM_DIMS      = 3;
    localparam int NUM_VERTS     = 3;
    localparam int PIPE_DEPTH    = 7;    // register stages from input to result

endpackage

[rtl/tbo_edge_axis.sv]
// One edge cross box-axis separating test, two register stages.
`timescale 1ns / 1ps

module tbo_edge_axis
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 21
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [NUM_VERTS-1:0][COORD_BITS:0]      i_vj,  // vertex coords on first axis lane
    input  logic [NUM_VERTS-1:0][COORD_BITS:0]      i_vk,  // vertex coords on second axis lane
    input  logic [COORD_BITS-1:0]                   i_hj,
    input  logic [COORD_BITS-1:0]                   i_hk,
    input  logic signed [COORD_BITS+1:0]            i_a,   // axis component on first lane
    input  logic signed [COORD_BITS+1:0]            i_b,   // axis component on second lane
    output logic                                    o_sep
);

    localparam int C  = COORD_BITS;
    localparam int PW = 2 * C + 3;
    localparam int SW = 2 * C + 4;
    localparam int RW = 2 * C + 1;

    logic signed [C+1:0]  w_nega, w_negb;
    logic [C:0]           w_absa, w_absb;
    logic signed [PW-1:0] r_pj [NUM_VERTS];
    logic signed [PW-1:0] r_pk [NUM_VERTS];
    logic [RW-1:0]        r_rj, r_rk;
    logic signed [SW-1:0] w_p [NUM_VERTS];
    logic signed [SW-1:0] w_mn, w_mx, w_r;
    logic                 r_sep;

    assign w_nega = -i_a;
    assign w_negb = -i_b;
    assign w_absa = i_a[C+1] ? w_nega[C:0] : i_a[C:0];
    assign w_absb = i_b[C+1] ? w_negb[C:0] : i_b[C:0];

    // products and radius terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_VERTS; i++) begin
                r_pj[i] <= $signed(i_vj[i]) * i_a;
                r_pk[i] <= $signed(i_vk[i]) * i_b;
            end
            r_rj <= RW'(i_hj * w_absa);
            r_rk <= RW'(i_hk * w_absb);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_VERTS; i++) begin
            w_p[i] = SW'(r_pj[i]) + SW'(r_pk[i]);
        end
        w_mn = w_p[0];
        w_mx = w_p[0];
        for (int i = 1; i < NUM_VERTS; i++) begin
            if (w_p[i] < w_mn) w_mn = w_p[i];
            if (w_p[i] > w_mx) w_mx = w_p[i];
        end
        w_r = $signed({3'b000, r_rj}) + $signed({3'b000, r_rk});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sep <= (w_mn > w_r) || (w_mx < -w_r);
        end
    end

    assign o_sep = r_sep;

endmodule

[rtl/tbo_normal.sv]
// Triangle normal projection and box radius, four register stages.
`timescale 1ns / 1ps

module tbo_normal
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 21
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [NUM_DIMS-1:0][COORD_BITS+1:0]     i_e0,
    input  logic [NUM_DIMS-1:0][COORD_BITS+1:0]     i_e1,
    input  logic [NUM_DIMS-1:0][COORD_BITS:0]       i_v0,
    input  logic [NUM_DIMS-1:0][COORD_BITS-1:0]     i_h,
    output logic signed [3*COORD_BITS+7:0]          o_d,
    output logic signed [3*COORD_BITS+7:0]          o_r
);

    localparam int C   = COORD_BITS;
    localparam int MW  = 2 * C + 4;        // edge component product
    localparam int NW  = 2 * C + 5;        // normal component
    localparam int AW  = 2 * C + 4;        // normal magnitude
    localparam int K   = C + 3;            // split point of the normal
    localparam int DW  = 3 * C + 8;
    localparam int DLW = 2 * C + 5;
    localparam int DHW = 2 * C + 3;
    localparam int RLW = 2 * C + 3;
    localparam int RHW = 2 * C + 1;

    logic signed [MW-1:0]  r_m [6];
    logic [NUM_DIMS-1:0][C:0]   r_v0a, r_v0b;
    logic [NUM_DIMS-1:0][C-1:0] r_ha, r_hb;
    logic signed [NW-1:0]  w_n [NUM_DIMS];
    logic signed [NW-1:0]  r_n [NUM_DIMS];
    logic [AW-1:0]         r_an [NUM_DIMS];
    logic signed [DLW-1:0] r_pdl [NUM_DIMS];
    logic signed [DHW-1:0] r_pdh [NUM_DIMS];
    logic [RLW-1:0]        r_prl [NUM_DIMS];
    logic [RHW-1:0]        r_prh [NUM_DIMS];
    logic signed [DW-1:0]  w_d;
    logic [DW-1:0]         w_r;
    logic signed [DW-1:0]  r_d, r_r;

    // cross(e0, e1) partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= $signed(i_e0[1]) * $signed(i_e1[2]);
            r_m[1] <= $signed(i_e0[2]) * $signed(i_e1[1]);
            r_m[2] <= $signed(i_e0[2]) * $signed(i_e1[0]);
            r_m[3] <= $signed(i_e0[0]) * $signed(i_e1[2]);
            r_m[4] <= $signed(i_e0[0]) * $signed(i_e1[1]);
            r_m[5] <= $signed(i_e0[1]) * $signed(i_e1[0]);
            r_v0a  <= i_v0;
            r_ha   <= i_h;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_DIMS; k++) begin
            w_n[k] = NW'(r_m[2*k]) - NW'(r_m[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_DIMS; k++) begin
                r_n[k]  <= w_n[k];
                r_an[k] <= w_n[k][NW-1] ? AW'(-w_n[k]) : AW'(w_n[k]);
            end
            r_v0b <= r_v0a;
            r_hb  <= r_ha;
        end
    end

    // split the normal so each multiplier stays narrow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_DIMS; k++) begin
                r_pdl[k] <= $signed(r_v0b[k]) * $signed({1'b0, r_n[k][K-1:0]});
                r_pdh[k] <= $signed(r_v0b[k]) * $signed(r_n[k][NW-1:K]);
                r_prl[k] <= RLW'(r_hb[k] * r_an[k][K-1:0]);
                r_prh[k] <= RHW'(r_hb[k] * r_an[k][AW-1:K]);
            end
        end
    end

    always_comb begin
        w_d = '0;
        w_r = '0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            w_d = w_d + (DW'(r_pdh[k]) <<< K) + DW'(r_pdl[k]);
            w_r = w_r + (DW'(r_prh[k]) << K) + DW'(r_prl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= w_d;
            r_r <= $signed(w_r);
        end
    end

    assign o_d = r_d;
    assign o_r = r_r;

endmodule

[rtl/triangle_box_overlap_test.sv]
// Top level: triangle / axis-aligned box separating axis overlap test.
//
//  channel   dir  tdata fields (low bit up)                         tuser
//  s_*       in   box_center, box_half_size, vertex_a/b/c (63 each)   -
//  m_*       out  overlap (bit 0)                                     -
//
// Seven register stages from accepted item to result; one item per cycle while the output is not stalled.
// Latency is set by the normal path: cross product, normal and magnitude, split products, sums, compare.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// A stalled result freezes every stage; o_s_tready drops only while the
// output holds an item that is not taken.
`timescale 1ns / 1ps

module triangle_box_overlap_test
    import tbo_pkg::*;
#(
    parameter int COORD_BITS = 21
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // box_center[62:0], box_half_size[125:63], vertex_a[188:126],
    // vertex_b[251:189], vertex_c[314:252], zero pad above
    input  logic [S_TDATA_BITS-1:0] i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // overlap[0], zero pad above
    output logic [M_TDATA_BITS-1:0] o_m_tdata
);

    localparam int C  = COORD_BITS;
    localparam int DW = 3 * C + 8;

    logic                              w_en, w_acc;
    logic [PIPE_DEPTH:1]               r_vld;
    logic [NUM_VERTS-1:0][NUM_DIMS-1:0][C:0]   w_v, r_v, r_v2;
    logic [NUM_DIMS-1:0][C-1:0]                w_h, r_h, r_h2;
    logic [NUM_VERTS-1:0][NUM_DIMS-1:0][C+1:0] r_e;
    logic                              w_box;
    logic                              r_box3, r_box4, r_box5, r_sep5, r_sep6;
    logic [8:0]                        w_esep;
    logic signed [DW-1:0]              w_d, w_r;
    logic                              w_nsep;
    logic                              r_overlap;

    assign w_en       = !r_vld[PIPE_DEPTH] || i_m_tready;
    assign o_s_tready = w_en;
    assign w_acc      = i_s_tvalid && w_en;

    // unpack, move vertices to box-center frame
    always_comb begin
        for (int k = 0; k < NUM_DIMS; k++) begin
            w_h[k] = i_s_tdata[FIELD_BITS + k*C +: C];
            for (int i = 0; i < NUM_VERTS; i++) begin
                w_v[i][k] = (C+1)'($signed(i_s_tdata[(2+i)*FIELD_BITS + k*C +: C]))
                          - (C+1)'($signed(i_s_tdata[k*C +: C]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-1:1], w_acc};
        end
    end

    // box-axis tests on the centered vertices
    always_comb begin
        logic signed [C:0]   mn, mx;
        logic signed [C+1:0] hh;
        w_box = 1'b0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            mn = $signed(r_v[0][k]);
            mx = $signed(r_v[0][k]);
            for (int i = 1; i < NUM_VERTS; i++) begin
                if ($signed(r_v[i][k]) < mn) mn = $signed(r_v[i][k]);
                if ($signed(r_v[i][k]) > mx) mx = $signed(r_v[i][k]);
            end
            hh = $signed({2'b00, r_h[k]});
            if ((C+2)'(mn) > hh || (C+2)'(mx) < -hh) w_box = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v  <= w_v;
            r_h  <= w_h;
            r_v2 <= r_v;
            r_h2 <= r_h;
            for (int i = 0; i < NUM_VERTS; i++) begin
                for (int k = 0; k < NUM_DIMS; k++) begin
                    r_e[i][k] <= (C+2)'($signed(r_v[i][k]))
                               - (C+2)'($signed(r_v[(i+1) % NUM_VERTS][k]));
                end
            end
            r_box3    <= w_box;
            r_box4    <= r_box3;
            r_box5    <= r_box4;
            r_sep5    <= (|w_esep) || r_box5;
            r_sep6    <= r_sep5;
            r_overlap <= !(r_sep6 || w_nsep);
        end
    end

    // edge cross box-axis tests, one per triangle edge and box axis
    for (genvar gi = 0; gi < NUM_VERTS; gi++) begin : g_edge
        for (genvar gu = 0; gu < NUM_DIMS; gu++) begin : g_axis
            localparam int J = (gu == 0) ? 1 : 0;
            localparam int K = (gu == 2) ? 1 : 2;
            logic signed [C+1:0] w_a, w_b;
            if (gu == 0) begin : g_x
                assign w_a = $signed(r_e[gi][2]);
                assign w_b = -$signed(r_e[gi][1]);
            end else if (gu == 1) begin : g_y
                assign w_a = -$signed(r_e[gi][2]);
                assign w_b = $signed(r_e[gi][0]);
            end else begin : g_z
                assign w_a = $signed(r_e[gi][1]);
                assign w_b = -$signed(r_e[gi][0]);
            end
            tbo_edge_axis #(.COORD_BITS(COORD_BITS)) u_axis (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_vj  ({r_v2[2][J], r_v2[1][J], r_v2[0][J]}),
                .i_vk  ({r_v2[2][K], r_v2[1][K], r_v2[0][K]}),
                .i_hj  (r_h2[J]),
                .i_hk  (r_h2[K]),
                .i_a   (w_a),
                .i_b   (w_b),
                .o_sep (w_esep[gi*NUM_DIMS + gu])
            );
        end
    end

    tbo_normal #(.COORD_BITS(COORD_BITS)) u_normal (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_e0  (r_e[0]),
        .i_e1  (r_e[1]),
        .i_v0  (r_v2[0]),
        .i_h   (r_h2),
        .o_d   (w_d),
        .o_r   (w_r)
    );

    assign w_nsep = (w_d > w_r) || (w_d < -w_r);

    assign o_m_tvalid = r_vld[PIPE_DEPTH];
    assign o_m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, r_overlap};

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && $stable(r_sep6) && $stable(r_overlap))
        else $error("pipeline moved during output stall");

    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH] && !i_m_tready |-> !o_s_tready)
        else $error("input taken while result is held");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && !w_acc |=> !r_vld[1])
        else $error("stage one valid without an accepted item");

endmodule

[verif/tb_triangle_box_overlap_test.sv]
// Testbench for the triangle / box separating axis overlap block.
`timescale 1ns / 1ps

module tb_triangle_box_overlap_test;
    import tbo_pkg::*;

    localparam int C = 21;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vc;
        logic [FIELD_BITS-1:0] vb;
        logic [FIELD_BITS-1:0] va;
        logic [FIELD_BITS-1:0] half;
        logic [FIELD_BITS-1:0] center;
    } t_pair;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [S_TDATA_BITS-1:0] i_s_tdata;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [M_TDATA_BITS-1:0] o_m_tdata;

    t_pair pending_pairs[$];
    bit    expected_overlap[$];
    int    mismatches;
    int    results_seen;
    int    overlaps_seen;
    int    idle_cycles;
    bit    stim_done;
    bit    quiet_stretch;

    triangle_box_overlap_test dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sget(logic [FIELD_BITS-1:0] w, int k);
        logic signed [C-1:0] v;
        v = w[k*C +: C];
        return longint'(v);
    endfunction

    function automatic longint absv(longint a);
        return a < 0 ? -a : a;
    endfunction

    // true if this axis splits the triangle from the box
    function automatic bit axis_splits(longint v[3][3], longint h[3], longint ax[3]);
        longint p[3];
        longint mn, mx, r;
        for (int i = 0; i < 3; i++)
            p[i] = v[i][0] * ax[0] + v[i][1] * ax[1] + v[i][2] * ax[2];
        mn = p[0];
        mx = p[0];
        for (int i = 1; i < 3; i++) begin
            if (p[i] < mn) mn = p[i];
            if (p[i] > mx) mx = p[i];
        end
        r = h[0] * absv(ax[0]) + h[1] * absv(ax[1]) + h[2] * absv(ax[2]);
        return mn > r || mx < -r;
    endfunction

    function automatic bit predict_overlap(t_pair t);
        longint h[3], c[3], v[3][3], e[3][3], ax[3], n[3];
        logic [FIELD_BITS-1:0] vw[3];
        logic signed [127:0] d, r;
        bit split;
        split = 1'b0;
        vw[0] = t.va;
        vw[1] = t.vb;
        vw[2] = t.vc;
        for (int k = 0; k < 3; k++) begin
            c[k] = sget(t.center, k);
            h[k] = longint'({1'b0, t.half[k*C +: C]});
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = sget(vw[i], k) - c[k];
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                e[i][k] = v[i][k] - v[(i + 1) % 3][k];
        for (int i = 0; i < 3; i++) begin
            ax = '{0, e[i][2], -e[i][1]};
            split |= axis_splits(v, h, ax);
            ax = '{-e[i][2], 0, e[i][0]};
            split |= axis_splits(v, h, ax);
            ax = '{e[i][1], -e[i][0], 0};
            split |= axis_splits(v, h, ax);
        end
        for (int k = 0; k < 3; k++) begin
            ax = '{0, 0, 0};
            ax[k] = 1;
            split |= axis_splits(v, h, ax);
        end
        n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        d = 0;
        r = 0;
        for (int k = 0; k < 3; k++) begin
            d += 128'(signed'(n[k])) * 128'(signed'(v[0][k]));
            r += 128'(signed'(h[k])) * 128'(signed'(absv(n[k])));
        end
        if (d - r > 0 || d + r < 0) split = 1'b1;
        return !split;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pack3(longint x, longint y, longint z);
        logic [FIELD_BITS-1:0] w;
        w = '0;
        w[0 +: C] = x[C-1:0];
        w[C +: C] = y[C-1:0];
        w[2*C +: C] = z[C-1:0];
        return w;
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_field();
        return FIELD_BITS'({$urandom, $urandom});
    endfunction

    // coordinate near a center, so most pairs land close to the box
    function automatic longint near(longint base, int spread);
        return base + longint'($urandom_range(2 * spread)) - longint'(spread);
    endfunction

    task automatic queue_pair(logic [FIELD_BITS-1:0] cw, logic [FIELD_BITS-1:0] hw,
                              logic [FIELD_BITS-1:0] aw, logic [FIELD_BITS-1:0] bw,
                              logic [FIELD_BITS-1:0] ccw);
        t_pair t;
        t.center = cw;
        t.half = hw;
        t.va = aw;
        t.vb = bw;
        t.vc = ccw;
        pending_pairs = {pending_pairs, t};
    endtask

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                expected_overlap = {expected_overlap,
                    predict_overlap(t_pair'(i_s_tdata[NUM_IN_FIELDS*FIELD_BITS-1:0]))};
            end
            if (pending_pairs.size() != 0 && (quiet_stretch || $urandom_range(99) >= 17)) begin
                i_s_tdata <= S_TDATA_BITS'(pending_pairs.pop_front());
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                overlaps_seen += o_m_tdata[0];
                if (expected_overlap.size() == 0)
                    report_mismatch("result with nothing expected");
                else if (o_m_tdata[0] !== expected_overlap.pop_front())
                    report_mismatch($sformatf("overlap got %b", o_m_tdata[0]));
            end
            i_m_tready <= quiet_stretch || $urandom_range(99) >= 17;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [FIELD_BITS-1:0] maxpos, maxneg, allone;
        longint cx, cy, cz, hx;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        overlaps_seen = 0;
        idle_cycles = 0;
        stim_done = 0;
        quiet_stretch = 0;
        maxpos = pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        maxneg = pack3(-(1 <<< 20), -(1 <<< 20), -(1 <<< 20));
        allone = '1;

        // directed: extremes, touching, degenerate, huge half size
        queue_pair('0, '0, '0, '0, '0);
        queue_pair(allone, allone, allone, allone, allone);
        queue_pair(maxneg, allone, maxpos, maxneg, maxpos);
        queue_pair(maxpos, '0, maxneg, maxneg, maxneg);
        queue_pair(maxneg, maxpos, maxpos, maxpos, maxneg);
        queue_pair('0, pack3(1024, 1024, 1024), pack3(1024, 0, 0),
                   pack3(3000, 0, 0), pack3(3000, 500, 0));
        queue_pair('0, pack3(1024, 1024, 1024), pack3(1025, 0, 0),
                   pack3(3000, 0, 0), pack3(3000, 500, 0));
        queue_pair('0, pack3(100, 100, 100), pack3(0, 0, 500),
                   pack3(10, 0, 500), pack3(0, 10, 500));
        queue_pair('0, pack3(100, 100, 100), pack3(0, 0, 100),
                   pack3(10, 0, 100), pack3(0, 10, 100));
        queue_pair('0, pack3(100, 100, 100), pack3(300, 300, 0),
                   pack3(300, 300, 0), pack3(300, 300, 0));
        queue_pair('0, pack3(100, 100, 100), pack3(250, -50, 0),
                   pack3(-50, 250, 0), pack3(250, 250, 0));
        queue_pair('0, pack3(100, 100, 100), pack3(200, 0, 0),
                   pack3(0, 200, 0), pack3(0, 0, 200));
        queue_pair('0, pack3(1 <<< 20, 1 <<< 20, 1 <<< 20), maxneg, maxpos, maxneg);
        queue_pair(maxpos, pack3(5, 5, 5), '0, pack3(7, 3, 1), pack3(-9, 2, 8));
        queue_pair(rand_field(), rand_field(), rand_field(), rand_field(), rand_field());

        for (int n = 0; n < 2000; n++) begin
            if ($urandom_range(9) < 2) begin
                queue_pair(rand_field(), rand_field(), rand_field(), rand_field(),
                           rand_field());
            end else begin
                int sp;
                sp = (n % 50 == 0) ? (1 << 19) : $urandom_range(4000, 10);
                cx = $signed(C'($urandom));
                cy = $signed(C'($urandom));
                cz = $signed(C'($urandom));
                hx = longint'($urandom_range(sp));
                queue_pair(pack3(cx, cy, cz),
                           pack3(hx, longint'($urandom_range(sp)),
                                 longint'($urandom_range(sp))),
                           pack3(near(cx, sp), near(cy, sp), near(cz, sp)),
                           pack3(near(cx, sp), near(cy, sp), near(cz, sp)),
                           pack3(near(cx, sp), near(cy, sp), near(cz, sp)));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (400) @(posedge i_clk);
        quiet_stretch = 1;
        repeat (300) @(posedge i_clk);
        quiet_stretch = 0;
        wait (pending_pairs.size() == 0);
        @(posedge i_clk);
        while (i_s_tvalid || expected_overlap.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);

        $display("Checked %0d triangle/box pairs, %0d overlapping, %0d disjoint.",
                 results_seen, overlaps_seen, results_seen - overlaps_seen);
        if (mismatches == 0 && expected_overlap.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
